FILE: hw/rtl/dstu_pkg.sv
// Package for the decimal string to unsigned converter.
// Payload structs, parse phase codes and limit constants; no dependencies.
`default_nettype none

package dstu_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty_req;
  } dstu_in_t;

  typedef struct packed {
    logic [62:0] value;
    logic        status;
  } dstu_out_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [62:0] acc;
  } dstu_state_t;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_FAIL   = 2'd3;

  localparam logic [1:0] RW_8  = 2'd0;
  localparam logic [1:0] RW_16 = 2'd1;
  localparam logic [1:0] RW_32 = 2'd2;
  localparam logic [1:0] RW_64 = 2'd3;

  localparam logic [62:0] LIMIT_DIV10 = 63'd922337203685477580;
  localparam logic [3:0]  LIMIT_MOD10 = 4'd7;

  localparam logic [62:0] MAX_U8  = 63'd255;
  localparam logic [62:0] MAX_U16 = 63'd65535;
  localparam logic [62:0] MAX_U32 = 63'd4294967295;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

endpackage

`default_nettype wire

FILE: hw/rtl/dstu_step.sv
// One parse step: next phase/accumulator and the result for a final character.
// Depends on dstu_pkg.
`default_nettype none

module dstu_step (
  input  wire dstu_pkg::dstu_in_t    item,
  input  wire dstu_pkg::dstu_state_t st,
  input  wire [1:0]                  result_width,
  output dstu_pkg::dstu_state_t      st_nxt,
  output logic                       produces,
  output dstu_pkg::dstu_out_t        res
);

  logic        is_digit;
  logic [3:0]  digit;
  logic        ovf;
  logic [62:0] acc_mul;
  logic [1:0]  phase_step;
  logic [62:0] acc_step;
  logic        fits;

  assign is_digit = (item.ch >= dstu_pkg::CH_ZERO) && (item.ch <= dstu_pkg::CH_NINE);
  assign digit    = 4'(item.ch - dstu_pkg::CH_ZERO);
  assign ovf      = (st.acc > dstu_pkg::LIMIT_DIV10) ||
                    ((st.acc == dstu_pkg::LIMIT_DIV10) && (digit > dstu_pkg::LIMIT_MOD10));
  // x*10 = x*8 + x*2
  assign acc_mul  = {st.acc[59:0], 3'b000} + {st.acc[61:0], 1'b0} + {59'd0, digit};

  always_comb begin
    phase_step = st.phase;
    acc_step   = st.acc;
    unique case (st.phase)
      dstu_pkg::PH_START, dstu_pkg::PH_SIGN, dstu_pkg::PH_DIGITS: begin
        if (st.phase == dstu_pkg::PH_START && item.ch == dstu_pkg::CH_PLUS) begin
          phase_step = dstu_pkg::PH_SIGN;
        end else if (is_digit) begin
          if (ovf) begin
            phase_step = dstu_pkg::PH_FAIL;
          end else begin
            phase_step = dstu_pkg::PH_DIGITS;
            acc_step   = acc_mul;
          end
        end else begin
          phase_step = dstu_pkg::PH_FAIL;
        end
      end
      default: begin
        phase_step = st.phase;
      end
    endcase
  end

  always_comb begin
    unique case (result_width)
      dstu_pkg::RW_8:  fits = acc_step <= dstu_pkg::MAX_U8;
      dstu_pkg::RW_16: fits = acc_step <= dstu_pkg::MAX_U16;
      dstu_pkg::RW_32: fits = acc_step <= dstu_pkg::MAX_U32;
      default:         fits = 1'b1;
    endcase
  end

  always_comb begin
    produces = item.last || item.empty_req;
    if (item.empty_req) begin
      res.value = '0;
      res.status = 1'b1;
    end else if (phase_step == dstu_pkg::PH_DIGITS && fits) begin
      res.value = acc_step;
      res.status = 1'b0;
    end else begin
      res.value = '0;
      res.status = 1'b1;
    end
    if (produces) begin
      st_nxt.phase = dstu_pkg::PH_START;
      st_nxt.acc   = '0;
    end else begin
      st_nxt.phase = phase_step;
      st_nxt.acc   = acc_step;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/decimal_string_to_unsigned_top.sv
// Top level of the decimal string to unsigned converter.
// Depends on dstu_pkg and dstu_step.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one ASCII character per
//   transaction with a last mark and an empty-string flag. Output channel
//   (out_valid/out_stall/out_data) carries one transaction per string: the
//   63-bit value and a status bit (1 = failed, value then 0).
//   cfg_we/cfg_wdata set the result width (0=8, 1=16, 2=32, 3=64 bits
//   capped at 2^63-1); write only while the block is idle.
//   Throughput: one character per cycle, except while a final character waits
//   behind a stalled result. Pipeline: a final character is held in the input
//   register and its result is loaded into the result register, which drives
//   out_valid; the depth is the input register plus the result register.
//   The parse step (multiply by ten as shift-add plus the width compare) sits
//   between those two registers.
//   Reset (rst_n low, synchronous) empties both registers, clears the parse
//   state and sets the width to 64 bits.
//   While the receiver stalls, the result register holds; characters that
//   end no string keep flowing, and in_stall rises only when a final
//   character is waiting behind a stalled result.
`default_nettype none

module decimal_string_to_unsigned_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire dstu_pkg::dstu_in_t in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output dstu_pkg::dstu_out_t    out_data,
  input  wire                    cfg_we,
  input  wire [1:0]              cfg_wdata
);

  logic                  in_vld_r;
  dstu_pkg::dstu_in_t    in_r;
  dstu_pkg::dstu_state_t st_r;
  dstu_pkg::dstu_state_t st_nxt;
  logic [1:0]            width_r;
  logic                  out_vld_r;
  dstu_pkg::dstu_out_t   out_r;
  logic                  produces;
  dstu_pkg::dstu_out_t   res;
  logic                  advance;

  dstu_step u_step (
    .item         (in_r),
    .st           (st_r),
    .result_width (width_r),
    .st_nxt       (st_nxt),
    .produces     (produces),
    .res          (res)
  );

  assign advance   = in_vld_r && (!produces || !out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      width_r   <= dstu_pkg::RW_64;
      st_r.phase <= dstu_pkg::PH_START;
      st_r.acc   <= '0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && produces) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (advance && produces) begin
      out_r <= res;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.value == '0)
    else $error("failed result carries nonzero value");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == dstu_pkg::PH_START |-> st_r.acc == '0)
    else $error("accumulator not clear at start of string");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_vld_r && out_stall && in_vld_r && produces)
    else $error("input stalled without a blocked result");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance && produces |=> out_vld_r)
    else $error("final character gave no result");

endmodule

`default_nettype wire
